// ----- rtl/mpps_pkg.sv -----
// shared types and codes for the multi-policy process scheduler
// no dependencies; imported by every module of the block

package mpps_pkg;

  // event codes on the input channel
  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_EXIT      = 2'd1,
    ACT_SET_PRIO  = 2'd2,
    ACT_SET_SHARE = 2'd3
  } action_t;

  // scheduling policies
  typedef enum logic [1:0] {
    POL_RR     = 2'd0,
    POL_LOWEST = 2'd1,
    POL_PRIO   = 2'd2,
    POL_SHARE  = 2'd3
  } policy_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_DONE
  } state_t;

  // one slot record as held in the slot memory
  typedef struct packed {
    logic       run;
    logic [7:0] prio;
    logic [7:0] limit;
    logic [7:0] count;
  } slot_rec_t;

  // configuration map
  localparam int          CFG_ADDR_W     = 3;
  localparam int          CFG_DATA_W     = 32;
  localparam logic        REG_POLICY_IDX = 1'b0;
  localparam policy_t     POLICY_RESET   = POL_SHARE;
  localparam int          OUT_SLOT_W     = 3;

endpackage

// ----- rtl/mpps_slot_mem.sv -----
// per-slot state memory: one write port, one registered read port
// depends on mpps_pkg; entries never written read as their reset record

module mpps_slot_mem #(
  parameter int NUM_SLOTS = 5,
  parameter int SW        = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [SW-1:0]       rd_addr,
  output mpps_pkg::slot_rec_t rd_data,
  input  logic                wr_en,
  input  logic [SW-1:0]       wr_addr,
  input  mpps_pkg::slot_rec_t wr_data
);
  import mpps_pkg::*;

  slot_rec_t            mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r;
  slot_rec_t            q_r;
  logic                 q_vld_r;
  logic [SW-1:0]        q_addr_r;
  slot_rec_t            rst_rec;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r      <= mem[rd_addr];
      q_vld_r  <= valid_r[rd_addr];
      q_addr_r <= rd_addr;
    end
  end

  // written-entry flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // reset record: all fields zero, runnable for every slot except slot 0
  always_comb begin
    rst_rec     = '0;
    rst_rec.run = (q_addr_r != '0);
  end

  assign rd_data = q_vld_r ? q_r : rst_rec;

endmodule

// ----- rtl/mpps_cfg.sv -----
// configuration register block behind the apb-style port
// depends on mpps_pkg; holds the policy selection

module mpps_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mpps_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mpps_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mpps_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output mpps_pkg::policy_t                   policy
);
  import mpps_pkg::*;

  policy_t policy_r;
  logic    sel_policy;

  assign sel_policy = (paddr[CFG_ADDR_W-1] == REG_POLICY_IDX);

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_RESET;
    end else if (psel && penable && pwrite && sel_policy) begin
      policy_r <= policy_t'(pwdata[1:0]);
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (sel_policy) begin
      prdata = CFG_DATA_W'(policy_r);
    end
  end

  assign pready = 1'b1;
  assign policy = policy_r;

endmodule

// ----- rtl/mpps_ctrl.sv -----
// scheduling sequencer: read-modify-write of slot records and policy scans
// depends on mpps_pkg; drives mpps_slot_mem and owns the result register

module mpps_ctrl #(
  parameter int NUM_SLOTS = 5,
  parameter int SW        = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_action,
  input  logic [7:0]                          in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mpps_pkg::OUT_SLOT_W-1:0]     out_running_slot,
  output logic                                out_idle,
  input  mpps_pkg::policy_t                   policy,
  output logic                                rd_en,
  output logic [SW-1:0]                       rd_addr,
  input  mpps_pkg::slot_rec_t                 rd_data,
  output logic                                wr_en,
  output logic [SW-1:0]                       wr_addr,
  output mpps_pkg::slot_rec_t                 wr_data
);
  import mpps_pkg::*;

  localparam int CW = $clog2(2 * NUM_SLOTS + 1);
  localparam int XW = (SW > OUT_SLOT_W) ? SW : OUT_SLOT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);
  localparam logic [CW-1:0] LEN_ALL   = CW'(NUM_SLOTS);
  localparam logic [CW-1:0] LEN_LOW   = CW'(NUM_SLOTS - 1);
  localparam logic [CW-1:0] LEN_SHARE = CW'(2 * NUM_SLOTS);

  state_t        state_r, state_nxt;
  action_t       act_r, act_nxt;
  logic [7:0]    val_r, val_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic          idle_r, idle_nxt;
  logic [SW-1:0] ip_r, ip_nxt;
  logic [SW-1:0] ep_r, ep_nxt;
  logic [CW-1:0] ic_r, ic_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          ev_r, ev_nxt;
  logic          pass_r, pass_nxt;
  logic [7:0]    best_r, best_nxt;
  logic          any_r, any_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic          out_idle_r, out_idle_nxt;
  logic [XW-1:0] cur_x;
  logic          last;
  logic          found;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SW'(1);
  endfunction

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= SW'(1);
      idle_r      <= 1'b0;
      ev_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      idle_r      <= idle_nxt;
      ev_r        <= ev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    val_r      <= val_nxt;
    ip_r       <= ip_nxt;
    ep_r       <= ep_nxt;
    ic_r       <= ic_nxt;
    len_r      <= len_nxt;
    pass_r     <= pass_nxt;
    best_r     <= best_nxt;
    any_r      <= any_nxt;
    out_slot_r <= out_slot_nxt;
    out_idle_r <= out_idle_nxt;
  end

  assign cur_x = XW'(cur_r);
  assign last  = (ic_r == len_r);

  // next state, memory requests and result register
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    val_nxt       = val_r;
    cur_nxt       = cur_r;
    idle_nxt      = idle_r;
    ip_nxt        = ip_r;
    ep_nxt        = ep_r;
    ic_nxt        = ic_r;
    len_nxt       = len_r;
    ev_nxt        = ev_r;
    pass_nxt      = pass_r;
    best_nxt      = best_r;
    any_nxt       = any_r;
    out_valid_nxt = out_valid_r;
    out_slot_nxt  = out_slot_r;
    out_idle_nxt  = out_idle_r;
    rd_en         = 1'b0;
    rd_addr       = ip_r;
    wr_en         = 1'b0;
    wr_addr       = ep_r;
    wr_data       = rd_data;
    found         = 1'b0;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        // accept a transaction and fetch the running slot's record
        if (in_valid) begin
          act_nxt   = action_t'(in_action);
          val_nxt   = in_value;
          rd_en     = 1'b1;
          rd_addr   = cur_r;
          state_nxt = ST_FETCH;
        end
      end

      ST_FETCH: begin
        wr_addr = cur_r;
        case (act_r)
          ACT_SET_PRIO: begin
            wr_en        = 1'b1;
            wr_data.prio = val_r;
            state_nxt    = ST_DONE;
          end
          ACT_SET_SHARE: begin
            wr_en         = 1'b1;
            wr_data.limit = val_r;
            state_nxt     = ST_DONE;
          end
          default: begin
            // exit clears the runnable flag before the scan reads anything
            if (act_r == ACT_EXIT) begin
              wr_en       = 1'b1;
              wr_data.run = 1'b0;
            end
            ic_nxt   = '0;
            ev_nxt   = 1'b0;
            pass_nxt = 1'b0;
            best_nxt = 8'hFF;
            any_nxt  = 1'b0;
            case (policy)
              POL_RR: begin
                ip_nxt  = slot_inc(cur_r);
                len_nxt = LEN_ALL;
              end
              POL_LOWEST: begin
                ip_nxt  = SW'(1);
                len_nxt = LEN_LOW;
              end
              POL_PRIO: begin
                ip_nxt  = '0;
                len_nxt = LEN_ALL;
              end
              default: begin
                ip_nxt  = cur_r;
                len_nxt = LEN_SHARE;
              end
            endcase
            state_nxt = ST_SCAN;
          end
        endcase
      end

      ST_SCAN: begin
        // issue one read per cycle while positions remain
        if (!last) begin
          rd_en   = 1'b1;
          rd_addr = ip_r;
          ip_nxt  = slot_inc(ip_r);
          ic_nxt  = ic_r + CW'(1);
          ev_nxt  = 1'b1;
          ep_nxt  = ip_r;
        end else begin
          ev_nxt = 1'b0;
        end

        // evaluate the record read in the previous cycle
        if (ev_r) begin
          case (policy)
            POL_RR, POL_LOWEST: begin
              found = rd_data.run;
            end
            POL_PRIO: begin
              if (!pass_r) begin
                any_nxt = any_r | rd_data.run;
                if (rd_data.run && (rd_data.prio < best_r)) begin
                  best_nxt = rd_data.prio;
                end
              end else begin
                found = rd_data.run && (rd_data.prio <= best_r);
              end
            end
            default: begin
              if (rd_data.run) begin
                wr_en = 1'b1;
                if (rd_data.count < rd_data.limit) begin
                  wr_data.count = rd_data.count + 8'd1;
                  found         = 1'b1;
                end else begin
                  wr_data.count = '0;
                end
              end
            end
          endcase

          if (found) begin
            cur_nxt   = ep_r;
            idle_nxt  = 1'b0;
            ev_nxt    = 1'b0;
            state_nxt = ST_DONE;
          end else if (last) begin
            if ((policy == POL_PRIO) && !pass_r && any_nxt) begin
              // minimum known: walk again from the slot after the current one
              pass_nxt = 1'b1;
              ip_nxt   = slot_inc(cur_r);
              ic_nxt   = '0;
              len_nxt  = LEN_ALL;
            end else begin
              idle_nxt  = 1'b1;
              state_nxt = ST_DONE;
            end
          end
        end
      end

      ST_DONE: begin
        // load the result once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = cur_x[OUT_SLOT_W-1:0];
          out_idle_nxt  = idle_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_running_slot = out_slot_r;
  assign out_idle         = out_idle_r;

endmodule

// ----- rtl/multi_policy_process_scheduler.sv -----
// top level of the multi-policy process scheduler
// depends on mpps_pkg, mpps_cfg, mpps_slot_mem and mpps_ctrl
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid in_stall in_action in_value    | event in
//   result  | out_valid out_stall out_running_slot    | result out
//           | out_idle                                |
//   config  | psel penable pwrite paddr pwdata        | apb write/read
//           | prdata pready                           |
//
// set priority and set share pass through fetch and done before the result is valid.
// tick and exit pass fetch, the scan and done; at most NUM_SLOTS positions
// for round robin, NUM_SLOTS-1 for lowest slot, 2*NUM_SLOTS for share and
// 2*NUM_SLOTS for priority (two passes); the single read port of the slot
// memory reads one record per cycle during the scan.
// reset is synchronous and clears per-entry written flags at once, no sweep.
// one transaction is in flight; a stalled result waits in the output register.

module multi_policy_process_scheduler #(
  parameter int NUM_SLOTS = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_action,
  input  logic [7:0]                          in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mpps_pkg::OUT_SLOT_W-1:0]     out_running_slot,
  output logic                                out_idle,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mpps_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mpps_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mpps_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import mpps_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);

  policy_t       policy;
  logic          rd_en;
  logic [SW-1:0] rd_addr;
  slot_rec_t     rd_data;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  slot_rec_t     wr_data;

  // configuration registers
  mpps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .policy  (policy)
  );

  // slot record memory
  mpps_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .SW        (SW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // scheduling sequencer
  mpps_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .SW        (SW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_running_slot (out_running_slot),
    .out_idle         (out_idle),
    .policy           (policy),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data)
  );

endmodule
